/* design/ostt_pkg.sv */
// Shared types, codes and constants of the one-shot timer table.
`timescale 1ns / 1ps

package ostt_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int ID_W          = 32;
   localparam int TIME_W        = 32;

   typedef enum logic [1:0] {
      OP_SCHEDULE   = 2'd0,
      OP_REMOVE     = 2'd1,
      OP_REMOVE_ALL = 2'd2,
      OP_TICK       = 2'd3
   } op_type;

   localparam logic KIND_SCHEDULE = 1'b0;
   localparam logic KIND_FIRED    = 1'b1;

   typedef struct packed {
      logic              used;
      logic              dead;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] remain;
   } entry_type;

   localparam entry_type HOLE_ENTRY = '{used: 1'b0, dead: 1'b0, id: '0, remain: '0};

   typedef enum logic [2:0] {
      CELL_HOLD   = 3'd0,
      CELL_ROTATE = 3'd1,
      CELL_LOAD   = 3'd2,
      CELL_KILL   = 3'd3,
      CELL_SORT   = 3'd4
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic         parity;
   } cell_ctrl_type;

endpackage

/* design/ostt_cell.sv */
// One timer cell of the chain: holds one entry and trades it with its neighbors.
`timescale 1ns / 1ps

module ostt_cell
   import ostt_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT,
   parameter int IDX   = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          load_hit,
   input  entry_type     load_entry,
   input  entry_type     up_entry,
   input  entry_type     dn_entry,
   output entry_type     q
);

   localparam logic ODD    = 1'((IDX % 2) == 1);
   localparam bit   HAS_UP = (IDX < SLOTS - 1);
   localparam bit   HAS_DN = (IDX > 0);

   logic              used_ff, used_in;
   logic              dead_ff, dead_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [TIME_W-1:0] remain_ff, remain_in;

   assign q = '{used: used_ff, dead: dead_ff, id: id_ff, remain: remain_ff};

   always_comb begin
      used_in   = used_ff;
      dead_in   = dead_ff;
      id_in     = id_ff;
      remain_in = remain_ff;
      case (ctrl.cmd)
         CELL_ROTATE: begin
            used_in   = up_entry.used;
            dead_in   = up_entry.dead;
            id_in     = up_entry.id;
            remain_in = up_entry.remain;
         end
         CELL_LOAD: begin
            if (load_hit) begin
               used_in   = load_entry.used;
               dead_in   = load_entry.dead;
               id_in     = load_entry.id;
               remain_in = load_entry.remain;
            end
         end
         CELL_KILL: begin
            dead_in = dead_ff | used_ff;
         end
         CELL_SORT: begin
            if (HAS_UP && (ODD == ctrl.parity)) begin
               if (!used_ff && up_entry.used) begin
                  used_in   = up_entry.used;
                  dead_in   = up_entry.dead;
                  id_in     = up_entry.id;
                  remain_in = up_entry.remain;
               end
            end else if (HAS_DN && (ODD != ctrl.parity)) begin
               if (used_ff && !dn_entry.used) begin
                  used_in   = dn_entry.used;
                  dead_in   = dn_entry.dead;
                  id_in     = dn_entry.id;
                  remain_in = dn_entry.remain;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         dead_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
         dead_ff <= dead_in;
      end
      id_ff     <= id_in;
      remain_ff <= remain_in;
   end

endmodule

/* design/one_shot_timer_table_unit.sv */
// Top level of the one-shot timer table: cell chain, head unit and sequencer.
//
//   channel  ports                                         handshake
//   request  req_op, req_time_amount, req_target_id        req_valid / req_ready
//   response rsp_kind, rsp_timer_id, rsp_full_res, rsp_last rsp_valid / rsp_ready
//   config   csr_wr_data                                   csr_wr_en, no wait
//
// Schedule, remove all and a tick while disabled finish without leaving the idle state.
// Remove by id makes one rotation of the chain past cell 0.
// An enabled tick makes the rotation through the head unit,
// a flush of the held fired item, then SLOTS odd-even compaction steps.
// A response stalled on rsp_ready freezes the rotation at the next fired timer.
// Reset is synchronous and clears the used bits of all cells at once.
`timescale 1ns / 1ps

module one_shot_timer_table_unit
   import ostt_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_op,
   input  logic [TIME_W-1:0] req_time_amount,
   input  logic [ID_W-1:0]   req_target_id,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [ID_W-1:0]   rsp_timer_id,
   output logic              rsp_full_res,
   output logic              rsp_last,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);

   localparam int CW = $clog2(SLOTS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ROT,
      S_TAIL,
      S_SORT
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     step_ff, step_in;
   logic [CW-1:0]     w_ff, w_in;
   logic [ID_W-1:0]   id_counter_ff, id_counter_in;
   logic              enabled_ff, enabled_in;
   logic              tick_mode_ff, tick_mode_in;
   logic              found_ff, found_in;
   logic [TIME_W-1:0] amt_ff, amt_in;
   logic [ID_W-1:0]   tgt_ff, tgt_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]   pend_id_ff, pend_id_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]   rsp_timer_id_ff, rsp_timer_id_in;
   logic              rsp_full_res_ff, rsp_full_res_in;
   logic              rsp_last_ff, rsp_last_in;

   cell_ctrl_type     ctrl;
   entry_type         load_entry;
   entry_type         fb_entry;
   entry_type         head;
   entry_type         cell_q [SLOTS];
   logic [SLOTS-1:0]  load_hit;
   logic [SLOTS-1:0]  used_vec;

   logic              req_fire;
   logic              rsp_busy;
   logic              live;
   logic              fire;
   logic              hit;
   logic              stall;

   assign head      = cell_q[0];
   assign req_fire  = req_valid && req_ready;
   assign rsp_busy  = rsp_valid_ff && !rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && !rsp_busy;

   assign live  = head.used && !head.dead;
   assign fire  = tick_mode_ff && live && (head.remain < amt_ff);
   assign hit   = head.used && (head.id == tgt_ff) && !found_ff;
   assign stall = fire && pend_valid_ff && rsp_busy;

   always_comb begin
      if (tick_mode_ff) begin
         fb_entry.used   = live && !fire;
         fb_entry.dead   = 1'b0;
         fb_entry.id     = head.id;
         fb_entry.remain = (live && !fire) ? head.remain - amt_ff : head.remain;
      end else begin
         fb_entry.used   = head.used;
         fb_entry.dead   = head.dead | hit;
         fb_entry.id     = head.id;
         fb_entry.remain = head.remain;
      end
   end

   assign load_entry = '{used: 1'b1, dead: 1'b0, id: id_counter_ff + ID_W'(1),
                         remain: req_time_amount};

   genvar g;
   generate
      for (g = 0; g < SLOTS; g++) begin : g_cell
         entry_type up_e;
         entry_type dn_e;
         if (g == SLOTS - 1) begin : g_top
            assign up_e = fb_entry;
         end else begin : g_mid
            assign up_e = cell_q[g+1];
         end
         if (g == 0) begin : g_bot
            assign dn_e = HOLE_ENTRY;
         end else begin : g_low
            assign dn_e = cell_q[g-1];
         end
         assign load_hit[g] = (count_ff == CW'(g));
         assign used_vec[g] = cell_q[g].used;

         ostt_cell #(
            .SLOTS (SLOTS),
            .IDX   (g)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .load_hit   (load_hit[g]),
            .load_entry (load_entry),
            .up_entry   (up_e),
            .dn_entry   (dn_e),
            .q          (cell_q[g])
         );
      end
   endgenerate

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      step_in         = step_ff;
      w_in            = w_ff;
      id_counter_in   = id_counter_ff;
      enabled_in      = csr_wr_en ? csr_wr_data : enabled_ff;
      tick_mode_in    = tick_mode_ff;
      found_in        = found_ff;
      amt_in          = amt_ff;
      tgt_in          = tgt_ff;
      pend_valid_in   = pend_valid_ff;
      pend_id_in      = pend_id_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_kind_in     = rsp_kind_ff;
      rsp_timer_id_in = rsp_timer_id_ff;
      rsp_full_res_in = rsp_full_res_ff;
      rsp_last_in     = rsp_last_ff;
      ctrl.cmd        = CELL_HOLD;
      ctrl.parity     = step_ff[0];

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (op_type'(req_op))
                  OP_SCHEDULE: begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_SCHEDULE;
                     rsp_last_in  = 1'b1;
                     if (count_ff == CW'(SLOTS)) begin
                        rsp_timer_id_in = '0;
                        rsp_full_res_in = 1'b1;
                     end else begin
                        id_counter_in   = id_counter_ff + ID_W'(1);
                        count_in        = count_ff + CW'(1);
                        ctrl.cmd        = CELL_LOAD;
                        rsp_timer_id_in = id_counter_ff + ID_W'(1);
                        rsp_full_res_in = 1'b0;
                     end
                  end
                  OP_REMOVE: begin
                     tick_mode_in = 1'b0;
                     tgt_in       = req_target_id;
                     found_in     = 1'b0;
                     step_in      = '0;
                     state_in     = S_ROT;
                  end
                  OP_REMOVE_ALL: begin
                     ctrl.cmd = CELL_KILL;
                  end
                  OP_TICK: begin
                     if (enabled_ff) begin
                        tick_mode_in  = 1'b1;
                        amt_in        = req_time_amount;
                        pend_valid_in = 1'b0;
                        w_in          = '0;
                        step_in       = '0;
                        state_in      = S_ROT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ROT: begin
            if (!stall) begin
               ctrl.cmd = CELL_ROTATE;
               w_in     = w_ff + CW'(fb_entry.used);
               found_in = found_ff | hit;
               if (fire) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in    = 1'b1;
                     rsp_kind_in     = KIND_FIRED;
                     rsp_timer_id_in = pend_id_ff;
                     rsp_full_res_in = 1'b0;
                     rsp_last_in     = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_id_in    = head.id;
               end
               if (step_ff == CW'(SLOTS - 1)) begin
                  state_in = tick_mode_ff ? S_TAIL : S_IDLE;
               end else begin
                  step_in = step_ff + CW'(1);
               end
            end
         end
         S_TAIL: begin
            if (!pend_valid_ff || !rsp_busy) begin
               if (pend_valid_ff) begin
                  rsp_valid_in    = 1'b1;
                  rsp_kind_in     = KIND_FIRED;
                  rsp_timer_id_in = pend_id_ff;
                  rsp_full_res_in = 1'b0;
                  rsp_last_in     = 1'b1;
               end
               pend_valid_in = 1'b0;
               count_in      = w_ff;
               step_in       = '0;
               state_in      = S_SORT;
            end
         end
         S_SORT: begin
            ctrl.cmd = CELL_SORT;
            if (step_ff == CW'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end else begin
               step_in = step_ff + CW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         step_ff       <= '0;
         id_counter_ff <= '0;
         enabled_ff    <= 1'b1;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         step_ff       <= step_in;
         id_counter_ff <= id_counter_in;
         enabled_ff    <= enabled_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      w_ff            <= w_in;
      tick_mode_ff    <= tick_mode_in;
      found_ff        <= found_in;
      amt_ff          <= amt_in;
      tgt_ff          <= tgt_in;
      pend_id_ff      <= pend_id_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_timer_id_ff <= rsp_timer_id_in;
      rsp_full_res_ff <= rsp_full_res_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_timer_id = rsp_timer_id_ff;
   assign rsp_full_res = rsp_full_res_ff;
   assign rsp_last     = rsp_last_ff;

   a_idle_packed : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ($countones(used_vec) == int'(count_ff)))
      else $error("used cells do not match the fill count");

   a_idle_no_pend : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("fired item held while idle");

   a_full_reject : assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op == OP_SCHEDULE) && (count_ff == CW'(SLOTS)))
      |=> (rsp_valid_ff && rsp_full_res_ff && (id_counter_ff == $past(id_counter_ff))))
      else $error("full table did not reject schedule");

endmodule
